// ----- sv/vdps_pkg.sv -----
// Shared types and register codes for the variable-density stencil block.
package vdps_pkg;

	typedef struct packed {
		logic signed [31:0] pressure;
		logic        [30:0] density;
	} in_t;

	typedef struct packed {
		logic signed [31:0] ap_value;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [31:0] inv_dx_sq;
		logic [31:0] inv_dy_sq;
		logic [10:0] grid_width;
		logic [15:0] grid_height;
	} cfg_t;

	localparam logic [1:0] NB_WEST  = 2'd0;
	localparam logic [1:0] NB_EAST  = 2'd1;
	localparam logic [1:0] NB_NORTH = 2'd2;
	localparam logic [1:0] NB_SOUTH = 2'd3;

	typedef struct packed {
		logic [3:0][31:0] nb_p;
		logic [3:0][30:0] nb_d;
		logic [31:0]      ctr_p;
		logic [30:0]      ctr_d;
		logic [3:0]       en;
		logic             above;
		logic             own;
		logic             last;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_NORTH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEL,
		B_DIV,
		B_MUL,
		B_ACC,
		B_EMIT_A,
		B_EMIT_O
	} back_state_t;

	localparam logic [1:0] REG_INV_DX = 2'd0;
	localparam logic [1:0] REG_INV_DY = 2'd1;
	localparam logic [1:0] REG_GRID_W = 2'd2;
	localparam logic [1:0] REG_GRID_H = 2'd3;

endpackage

// ----- sv/vdps_ram.sv -----
// Generic simple dual-port RAM with registered read.
module vdps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/vdps_queue.sv -----
// Two-entry job queue between the front and back parts.
module vdps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vdps_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output vdps_pkg::job_t pop_data,
	output logic          empty
);
	import vdps_pkg::*;

	job_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end
endmodule

// ----- sv/vdps_front.sv -----
// Front part: accepts cells, runs the line buffers and builds stencil jobs.
module vdps_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  vdps_pkg::cfg_t cfg,
	input  logic           clr,
	input  logic           in_valid,
	output logic           in_stall,
	input  vdps_pkg::in_t  in_data,
	output logic           q_push,
	output vdps_pkg::job_t q_data,
	input  logic           q_full
);
	import vdps_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW = CW + 1;

	front_state_t  state_q, state_d;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	in_t           item_q;
	logic [31:0]   east_p_q, ctr_p_q, west_p_q;
	logic [30:0]   east_d_q, ctr_d_q, west_d_q;

	logic [CW:0]   eff_w;
	logic [15:0]   eff_h;
	logic [31:0]   c32, w32, r32, h32;
	logic [AW-1:0] east_addr, north_addr, raddr;
	logic [31:0]   rd_p;
	logic [30:0]   rd_d;
	logic          above, own, row_end, interior, need_push, advance;
	logic          accept, we;

	always_comb begin
		if (cfg.grid_width < 11'd3) begin
			eff_w = (CW+1)'(3);
		end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
			eff_w = (CW+1)'(MAX_WIDTH);
		end else begin
			eff_w = (CW+1)'(cfg.grid_width);
		end
		eff_h = (cfg.grid_height < 16'd3) ? 16'd3 : cfg.grid_height;
	end

	assign c32 = 32'(col_q);
	assign w32 = 32'(eff_w);
	assign r32 = 32'(row_q);
	assign h32 = 32'(eff_h);

	assign above    = (r32 >= 32'd1);
	assign interior = (r32 >= 32'd2) && (r32 + 32'd1 <= h32) &&
	                  (c32 >= 32'd1) && (c32 + 32'd2 <= w32);
	assign own      = (r32 + 32'd1 >= h32);
	assign row_end  = (c32 + 32'd1 >= w32);

	assign east_addr  = {~row_q[0], CW'({1'b0, col_q} + 1'b1)};
	assign north_addr = {row_q[0], col_q};
	assign raddr      = (state_q == F_IDLE) ? east_addr : north_addr;

	vdps_ram #(.WIDTH(32), .DEPTH(2 << CW)) u_p_ram (
		.clk   (clk),
		.we    (we),
		.waddr (north_addr),
		.wdata (item_q.pressure),
		.raddr (raddr),
		.rdata (rd_p)
	);

	vdps_ram #(.WIDTH(31), .DEPTH(2 << CW)) u_d_ram (
		.clk   (clk),
		.we    (we),
		.waddr (north_addr),
		.wdata (item_q.density),
		.raddr (raddr),
		.rdata (rd_d)
	);

	assign in_stall  = (state_q != F_IDLE);
	assign accept    = in_valid && (state_q == F_IDLE);
	assign need_push = above || own;

	always_comb begin
		q_data              = '0;
		q_data.nb_p[NB_WEST]  = west_p_q;
		q_data.nb_d[NB_WEST]  = west_d_q;
		q_data.nb_p[NB_EAST]  = east_p_q;
		q_data.nb_d[NB_EAST]  = east_d_q;
		q_data.nb_p[NB_NORTH] = rd_p;
		q_data.nb_d[NB_NORTH] = rd_d;
		q_data.nb_p[NB_SOUTH] = item_q.pressure;
		q_data.nb_d[NB_SOUTH] = item_q.density;
		q_data.ctr_p        = ctr_p_q;
		q_data.ctr_d        = ctr_d_q;
		q_data.en[NB_WEST]  = interior && (c32 >= 32'd2);
		q_data.en[NB_EAST]  = interior && (c32 + 32'd3 <= w32);
		q_data.en[NB_NORTH] = interior && (r32 >= 32'd3);
		q_data.en[NB_SOUTH] = interior && (r32 + 32'd1 < h32);
		q_data.above        = above;
		q_data.own          = own;
		q_data.last         = own && row_end;
	end

	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		q_push  = 1'b0;
		we      = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_NORTH;
				end
			end
			F_NORTH: begin
				state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!need_push || !q_full) begin
					advance = 1'b1;
					q_push  = need_push;
					we      = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (advance) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= own ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == F_NORTH) begin
			east_p_q <= rd_p;
			east_d_q <= rd_d;
		end
		if (advance) begin
			west_p_q <= ctr_p_q;
			west_d_q <= ctr_d_q;
			ctr_p_q  <= east_p_q;
			ctr_d_q  <= east_d_q;
		end
	end
endmodule

// ----- sv/vdps_back.sv -----
// Back part: coefficient division, flux products, accumulation and result output.
module vdps_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    inv_dx_sq,
	input  logic [31:0]    inv_dy_sq,
	input  logic           q_empty,
	output logic           q_pop,
	input  vdps_pkg::job_t q_data,
	output logic           out_valid,
	input  logic           out_stall,
	output vdps_pkg::out_t out_data
);
	import vdps_pkg::*;

	localparam int DW   = 32 + FRAC_BITS;
	localparam int CNTW = $clog2(DW + 1);
	localparam int TW   = 64 - FRAC_BITS;
	localparam int ACCW = TW + 3;
	localparam logic signed [ACCW-1:0] SMAX = ACCW'(64'sd2147483647);
	localparam logic signed [ACCW-1:0] SMIN = ACCW'(-64'sd2147483648);

	back_state_t     state_q, state_d;
	job_t            job_q;
	logic [1:0]      k_q;
	logic [31:0]     rem_q, dvs_q;
	logic [DW-1:0]   dvd_q, quo_q;
	logic [CNTW-1:0] cnt_q;
	logic [63:0]     prod_q;
	logic            neg_q;
	logic signed [ACCW-1:0] acc_q;
	logic            out_valid_q;
	out_t            out_q;

	logic            ld_job, ld_div, div_step, do_mul, do_acc, k_inc, emit_ld;
	out_t            emit_val;
	back_state_t     after_k;
	logic [31:0]     inv_sel, dsum, coef, rem_n;
	logic [32:0]     trial, diff, mag;
	logic            ge, can_ld;
	logic [63:0]     prod_n;
	logic [TW-1:0]   term;
	logic signed [ACCW-1:0] term_s;
	logic [31:0]     sat_v;

	assign inv_sel = k_q[1] ? inv_dy_sq : inv_dx_sq;
	assign dsum    = {1'b0, job_q.ctr_d} + {1'b0, job_q.nb_d[k_q]};

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign rem_n = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];

	assign coef  = (|quo_q[DW-1:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
	assign diff  = {job_q.nb_p[k_q][31], job_q.nb_p[k_q]} - {job_q.ctr_p[31], job_q.ctr_p};
	assign mag   = diff[32] ? (33'd0 - diff) : diff;
	assign prod_n = mag[32] ? {coef, 32'd0} : (coef * mag[31:0]);

	assign term   = prod_q[63:FRAC_BITS];
	assign term_s = neg_q ? -$signed({3'b000, term}) : $signed({3'b000, term});

	always_comb begin
		if (acc_q > SMAX) begin
			sat_v = 32'h7FFF_FFFF;
		end else if (acc_q < SMIN) begin
			sat_v = 32'h8000_0000;
		end else begin
			sat_v = acc_q[31:0];
		end
	end

	assign can_ld  = !out_valid_q || !out_stall;
	assign after_k = job_q.above ? B_EMIT_A : B_EMIT_O;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		ld_job   = 1'b0;
		ld_div   = 1'b0;
		div_step = 1'b0;
		do_mul   = 1'b0;
		do_acc   = 1'b0;
		k_inc    = 1'b0;
		emit_ld  = 1'b0;
		emit_val = '0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					ld_job  = 1'b1;
					state_d = B_SEL;
				end
			end
			B_SEL: begin
				if (job_q.en[k_q]) begin
					ld_div  = 1'b1;
					state_d = B_DIV;
				end else if (k_q == NB_SOUTH) begin
					state_d = after_k;
				end else begin
					k_inc = 1'b1;
				end
			end
			B_DIV: begin
				div_step = 1'b1;
				if (cnt_q == CNTW'(DW - 1)) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				do_mul  = 1'b1;
				state_d = B_ACC;
			end
			B_ACC: begin
				do_acc = 1'b1;
				if (k_q == NB_SOUTH) begin
					state_d = after_k;
				end else begin
					k_inc   = 1'b1;
					state_d = B_SEL;
				end
			end
			B_EMIT_A: begin
				emit_val.ap_value = sat_v;
				emit_val.last     = 1'b0;
				if (can_ld) begin
					emit_ld = 1'b1;
					state_d = job_q.own ? B_EMIT_O : B_IDLE;
				end
			end
			B_EMIT_O: begin
				emit_val.ap_value = '0;
				emit_val.last     = job_q.last;
				if (can_ld) begin
					emit_ld = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_job) begin
			job_q <= q_data;
			acc_q <= '0;
			k_q   <= NB_WEST;
		end else if (k_inc) begin
			k_q <= k_q + 2'd1;
		end
		if (ld_div) begin
			rem_q <= '0;
			dvs_q <= dsum;
			dvd_q <= {inv_sel, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			cnt_q <= '0;
		end else if (div_step) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (do_mul) begin
			prod_q <= prod_n;
			neg_q  <= diff[32];
		end
		if (do_acc) begin
			acc_q <= acc_q + term_s;
		end
		if (emit_ld) begin
			out_q <= emit_val;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ----- sv/variable_density_poisson_stencil.sv -----
// Top level: configuration registers, front, job queue and back of the stencil.
//
// Cells enter raster order on in_valid/in_stall/in_data (pressure, density).
// Results leave on out_valid/out_stall/out_data (ap_value, last). For a cell of
// row r >= 1, the result of the cell one row up leaves after it; cells of the
// last row also give their own zero result, with last set on the final cell.
// The front takes one cell at a time and holds in_stall until it is done with it:
// one line-buffer read per port access (east neighbour of the row above, then the
// north neighbour), and a push, where one is needed, that waits while the queue is full.
// The back works one job at a time through a shared restoring divider, one
// quotient bit per cycle, taking each active neighbour through division, flux
// product and accumulation, then loading each result into the output register.
// A two-entry job queue lets the front keep accepting while the back computes
// or while a result waits in the output register under out_stall.
// Reset clears the counters and restores the default registers; the line
// buffers are not cleared and hold valid data only once the grid writes them.
// Writing grid_width or grid_height restarts the grid at its first cell.
module variable_density_poisson_stencil #(
	parameter int MAX_WIDTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  vdps_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output vdps_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import vdps_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en, clr;
	logic       q_push, q_pop, q_full, q_empty;
	job_t       q_in, q_out;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign clr    = wr_en && ((idx == REG_GRID_W) || (idx == REG_GRID_H));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_dx_sq   <= 32'd65536;
			cfg_q.inv_dy_sq   <= 32'd65536;
			cfg_q.grid_width  <= 11'd64;
			cfg_q.grid_height <= 16'd64;
		end else if (wr_en) begin
			case (idx)
				REG_INV_DX: cfg_q.inv_dx_sq   <= pwdata;
				REG_INV_DY: cfg_q.inv_dy_sq   <= pwdata;
				REG_GRID_W: cfg_q.grid_width  <= pwdata[10:0];
				REG_GRID_H: cfg_q.grid_height <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INV_DX: prdata = cfg_q.inv_dx_sq;
			REG_INV_DY: prdata = cfg_q.inv_dy_sq;
			REG_GRID_W: prdata = {21'd0, cfg_q.grid_width};
			REG_GRID_H: prdata = {16'd0, cfg_q.grid_height};
			default:    prdata = '0;
		endcase
	end

	vdps_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clr      (clr),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_push   (q_push),
		.q_data   (q_in),
		.q_full   (q_full)
	);

	vdps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	vdps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.inv_dx_sq (cfg_q.inv_dx_sq),
		.inv_dy_sq (cfg_q.inv_dy_sq),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_out),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue underflow");

	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last) |-> (out_data.ap_value == 32'sd0))
		else $error("final result of grid is not zero");

	a_push_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_in.above || q_in.own))
		else $error("job without result queued");
endmodule

// ----- tb/variable_density_poisson_stencil_test.sv -----
// Testbench for the variable-density stencil: an edge-value grid and random grids checked against a predictor.
module variable_density_poisson_stencil_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vdps_pkg::*;

	localparam int MAXW = 1024;
	localparam int FB   = 16;

	class stencil_scoreboard;
		logic [31:0] inv_dx, inv_dy;
		logic [10:0] width_reg;
		logic [15:0] height_reg;
		logic [31:0] p_line [2][MAXW];
		logic [30:0] d_line [2][MAXW];
		int unsigned col, row;
		out_t expected_q[$];
		int errors, cells, results;

		function new();
			inv_dx = 32'd65536;
			inv_dy = 32'd65536;
			width_reg = 11'd64;
			height_reg = 16'd64;
			col = 0;
			row = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_INV_DX: inv_dx = val;
				REG_INV_DY: inv_dy = val;
				REG_GRID_W: begin
					width_reg = val[10:0];
					col = 0;
					row = 0;
				end
				REG_GRID_H: begin
					height_reg = val[15:0];
					col = 0;
					row = 0;
				end
				default: begin
				end
			endcase
		endfunction

		function longint unsigned coef(logic [31:0] inv, longint unsigned rho);
			longint unsigned q;
			if (rho == 0) return 64'hFFFF_FFFF;
			q = ({32'd0, inv} << FB) / rho;
			return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
		endfunction

		function longint flux(longint unsigned a, longint diff);
			longint unsigned mag;
			if (diff >= 0) begin
				mag = (a * longint'(diff)) >> FB;
				return longint'(mag);
			end
			mag = (a * longint'(-diff)) >> FB;
			return -longint'(mag);
		endfunction

		function void note(in_t item);
			int unsigned w, h, c, r, cur, up, tr;
			longint acc, pp;
			longint unsigned rp;
			out_t res;
			w = (width_reg < 3) ? 3 : (width_reg > MAXW) ? MAXW : width_reg;
			h = (height_reg < 3) ? 3 : height_reg;
			c = (col >= w) ? w - 1 : col;
			r = row;
			cur = r & 1;
			up = (r + 1) & 1;
			cells++;
			if (r >= 1) begin
				acc = 0;
				tr = r - 1;
				if (tr >= 1 && tr + 2 <= h && c >= 1 && c + 2 <= w) begin
					pp = longint'($signed(p_line[up][c]));
					rp = d_line[up][c];
					if (c - 1 >= 1)
						acc += flux(coef(inv_dx, rp + d_line[up][c-1]),
							longint'($signed(p_line[up][c-1])) - pp);
					if (c + 2 < w)
						acc += flux(coef(inv_dx, rp + d_line[up][c+1]),
							longint'($signed(p_line[up][c+1])) - pp);
					if (tr - 1 >= 1)
						acc += flux(coef(inv_dy, rp + d_line[cur][c]),
							longint'($signed(p_line[cur][c])) - pp);
					if (tr + 2 < h)
						acc += flux(coef(inv_dy, rp + item.density),
							longint'(item.pressure) - pp);
				end
				if (acc > 64'sd2147483647) acc = 64'sd2147483647;
				if (acc < -64'sd2147483648) acc = -64'sd2147483648;
				res.ap_value = acc[31:0];
				res.last = 1'b0;
				expected_q.push_back(res);
			end
			p_line[cur][c] = item.pressure;
			d_line[cur][c] = item.density;
			if (r + 1 >= h) begin
				res.ap_value = '0;
				res.last = (c + 1 >= w);
				expected_q.push_back(res);
			end
			if (c + 1 >= w) begin
				col = 0;
				row = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col = c + 1;
			end
		endfunction

		function void check(out_t got);
			out_t exp_r;
			results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result ap_value=%0d last=%0b", got.ap_value, got.last);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.ap_value !== exp_r.ap_value) begin
				$error("ap_value: expected %0d, got %0d", exp_r.ap_value, got.ap_value);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0b, got %0b", exp_r.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	in_t         in_data;
	out_t        out_data;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	stencil_scoreboard sb;
	bit busy_sides;
	int grids;

	variable_density_poisson_stencil dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[variable_density_poisson_stencil] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note(in_data);
		if (arst_n && out_valid && !out_stall) sb.check(out_data);
	end

	function int pick_gap();
		int r;
		if (!busy_sides) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	initial begin
		int g;
		out_stall = 1'b0;
		forever begin
			g = pick_gap();
			out_stall <= (g != 0);
			repeat (g == 0 ? $urandom_range(1, 6) : g) @(posedge clk);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_cell(logic [31:0] p, logic [30:0] d);
		int g;
		in_t item;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item.pressure = p;
		item.density = d;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function logic [31:0] rand_pressure(bit near);
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return near ? 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19))
				: $urandom;
		endcase
	endfunction

	function logic [30:0] rand_density();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(1, 4));
			3, 4: return 31'($urandom_range(1 << 14, 1 << 18));
			default: return 31'($urandom);
		endcase
	endfunction

	function logic [31:0] rand_inv();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2: return 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] edge_p [5];
		logic [30:0] edge_d [4];
		int n, w, h, cnt;
		bit near;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		busy_sides = 1'b1;
		grids = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		edge_p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd65536};
		edge_d = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd65536};
		write_reg(REG_INV_DX, 32'd65536);
		write_reg(REG_INV_DY, 32'hFFFF_FFFF);
		write_reg(REG_GRID_W, 32'd5);
		write_reg(REG_GRID_H, 32'd4);
		for (int i = 0; i < 20; i++)
			send_cell(edge_p[(i * 3) % 5], edge_d[(i * 7) % 4]);
		grids++;
		settle();

		n = 0;
		while (n < 500) begin
			busy_sides = ($urandom_range(0, 4) != 0);
			near = $urandom_range(0, 1);
			w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9);
			h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 7);
			write_reg(REG_INV_DX, rand_inv());
			write_reg(REG_INV_DY, rand_inv());
			write_reg(REG_GRID_W, w);
			write_reg(REG_GRID_H, h);
			w = w < 3 ? 3 : w;
			h = h < 3 ? 3 : h;
			cnt = w * h * $urandom_range(1, 3);
			if ($urandom_range(0, 5) == 0) cnt = $urandom_range(1, w * h);
			for (int i = 0; i < cnt; i++) begin
				if (n == 400 && i == w * 2) begin
					in_valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
				send_cell(rand_pressure(near), rand_density());
				n++;
			end
			grids++;
			settle();
		end

		busy_sides = 1'b1;
		write_reg(REG_INV_DX, 32'd65536);
		write_reg(REG_GRID_W, 32'd2047);
		write_reg(REG_GRID_H, 32'd65535);
		for (int i = 0; i < MAXW + 30; i++)
			send_cell(rand_pressure(1'b1), rand_density());
		settle();

		$display("covered %0d grids plus a full-width partial grid: %0d cells, %0d results",
			grids, sb.cells, sb.results);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[variable_density_poisson_stencil] OK");
		else
			$display("[variable_density_poisson_stencil] ERROR");
		$finish;
	end
endmodule
